### src/rrw_pkg.sv
// Package for the receive reorder window: sizes, codes and the structs
// that pass between the slot store, the buffer queue and the sequencer.
// No dependencies.
`default_nettype none

package rrw_pkg;

  // Built window depth and buffer queue depth.
  localparam int WINDOW  = 32;
  localparam int BUFFERS = 64;

  // Derived widths. The slot index is the low bits of a sequence number,
  // so the window depth is a power of two.
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int BUF_W  = $clog2(BUFFERS);
  localparam int CNT_W  = $clog2(BUFFERS + 1);
  localparam int RWIN_W = 6;
  localparam int SEQ_W  = 32;
  localparam int TAG_W  = 16;

  // Input action codes.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_POST = 1'b1;

  // Result kind codes.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_ACK
  } rrw_state_e;

  // Request to the slot store: keep a packet, or hand one out.
  typedef struct packed {
    logic              store;
    logic [SLOT_W-1:0] store_idx;
    logic [TAG_W-1:0]  store_tag;
    logic              take;
    logic [SLOT_W-1:0] take_idx;
  } slot_req_t;

  // Request to the buffer queue.
  typedef struct packed {
    logic             push;
    logic [TAG_W-1:0] push_tag;
    logic             pop;
  } queue_req_t;

  // Status of the buffer queue.
  typedef struct packed {
    logic full;
    logic empty;
    logic more_than_one;
  } queue_stat_t;

endpackage

`default_nettype wire

### src/rrw_slot_store.sv
// Window slot store: one valid bit per slot in flip-flops and a payload
// memory with a registered read port.
// Depends on rrw_pkg.
`default_nettype none

module rrw_slot_store
  import rrw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slot_req_t         req_i,
  output logic [WINDOW-1:0]      valid_o,
  output logic [TAG_W-1:0]       rd_tag_o
);

  logic [WINDOW-1:0] valid_q;
  logic [WINDOW-1:0] valid_d;
  logic [TAG_W-1:0]  payload_mem [WINDOW];
  logic [TAG_W-1:0]  rd_tag_q;

  // A stored packet marks its slot, a handed-out packet frees it.
  always_comb begin
    valid_d = valid_q;
    if (req_i.store) begin
      valid_d[req_i.store_idx] = 1'b1;
    end
    if (req_i.take) begin
      valid_d[req_i.take_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.store) begin
      payload_mem[req_i.store_idx] <= req_i.store_tag;
    end
    if (req_i.take) begin
      rd_tag_q <= payload_mem[req_i.take_idx];
    end
  end

  assign valid_o  = valid_q;
  assign rd_tag_o = rd_tag_q;

endmodule

`default_nettype wire

### src/rrw_buf_queue.sv
// Receive buffer queue: a FIFO memory of posted buffer handles with head,
// tail and fill count, and a registered read at the head.
// Depends on rrw_pkg.
`default_nettype none

module rrw_buf_queue
  import rrw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire queue_req_t       req_i,
  output queue_stat_t           stat_o,
  output logic [TAG_W-1:0]      rd_tag_o
);

  logic [TAG_W-1:0] buf_mem [BUFFERS];
  logic [TAG_W-1:0] rd_tag_q;
  logic [BUF_W-1:0] head_q, head_d;
  logic [BUF_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pointer and count update.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d = (tail_q == BUF_W'(BUFFERS - 1)) ? '0 : tail_q + 1'b1;
    end
    if (req_i.pop) begin
      head_d = (head_q == BUF_W'(BUFFERS - 1)) ? '0 : head_q + 1'b1;
    end
    unique case ({req_i.push, req_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Buffer memory: write at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      buf_mem[tail_q] <= req_i.push_tag;
    end
    if (req_i.pop) begin
      rd_tag_q <= buf_mem[head_q];
    end
  end

  assign stat_o.full          = (count_q == CNT_W'(BUFFERS));
  assign stat_o.empty         = (count_q == '0);
  assign stat_o.more_than_one = (count_q > CNT_W'(1));
  assign rd_tag_o             = rd_tag_q;

endmodule

`default_nettype wire

### src/rrw_seq.sv
// Sequencer of the receive reorder window: window check on arrivals,
// in-order delivery loop, acknowledgement, and the output register.
// Depends on rrw_pkg; drives rrw_slot_store and rrw_buf_queue.
`default_nettype none

module rrw_seq
  import rrw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [RWIN_W-1:0] recv_window_i,
  // Input channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [SEQ_W-1:0]  seq_num_i,
  input  wire logic [TAG_W-1:0]  payload_tag_i,
  input  wire logic [TAG_W-1:0]  buffer_tag_i,
  // Store side.
  output slot_req_t              slot_req_o,
  input  wire logic [WINDOW-1:0] slot_valid_i,
  input  wire logic [TAG_W-1:0]  slot_tag_i,
  output queue_req_t             queue_req_o,
  input  wire queue_stat_t       queue_stat_i,
  input  wire logic [TAG_W-1:0]  queue_tag_i,
  // Output channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [SEQ_W-1:0]       delivered_seq_o,
  output logic [TAG_W-1:0]       delivered_payload_o,
  output logic [TAG_W-1:0]       target_buffer_o,
  output logic [SEQ_W-1:0]       ack_next_o,
  output logic                   last_o
);

  rrw_state_e        state_q, state_d;
  logic [SEQ_W-1:0]  next_exp_q;
  logic              ack_q;
  logic [SEQ_W-1:0]  del_seq_q;
  logic              del_last_q;

  logic              out_valid_q;
  logic              kind_q;
  logic [SEQ_W-1:0]  seq_out_q;
  logic [TAG_W-1:0]  pay_out_q;
  logic [TAG_W-1:0]  buf_out_q;
  logic [SEQ_W-1:0]  ack_out_q;
  logic              last_out_q;

  logic [RWIN_W-1:0] win;
  logic [SEQ_W:0]    win_end;
  logic              in_window;
  logic              accept;
  logic              ack_hit;
  logic [SLOT_W-1:0] seq_idx;
  logic [SLOT_W-1:0] exp_idx;
  logic [SLOT_W-1:0] exp_idx_nxt;
  logic              deliver;
  logic              more_after;
  logic              out_free;
  logic              load_del;
  logic              load_ack;

  // Window check: a window above the built depth acts as the depth, and
  // the end is formed one bit wider with no wrap.
  assign win       = (recv_window_i > RWIN_W'(WINDOW)) ? RWIN_W'(WINDOW) : recv_window_i;
  assign win_end   = {1'b0, next_exp_q} + (SEQ_W + 1)'(win);
  assign in_window = ({1'b0, seq_num_i} >= {1'b0, next_exp_q}) &&
                     ({1'b0, seq_num_i} < win_end);

  assign accept  = in_valid_i && in_ready_o;
  assign ack_hit = (action_i == ACT_DATA) && in_window;

  // Slot indexes are the low bits of the sequence number.
  assign seq_idx     = seq_num_i[SLOT_W-1:0];
  assign exp_idx     = next_exp_q[SLOT_W-1:0];
  assign exp_idx_nxt = exp_idx + 1'b1;

  // A delivery needs a posted buffer and the expected packet in its slot.
  assign deliver    = !queue_stat_i.empty && slot_valid_i[exp_idx];
  assign more_after = queue_stat_i.more_than_one && slot_valid_i[exp_idx_nxt];

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (deliver) begin
          state_d = ST_EMIT;
        end else if (ack_q) begin
          state_d = ST_ACK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_CHECK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: store requests on accept, reads in the check state,
  // output register loads in the emit and ack states.
  always_comb begin
    in_ready_o            = 1'b0;
    slot_req_o.store      = 1'b0;
    slot_req_o.store_idx  = seq_idx;
    slot_req_o.store_tag  = payload_tag_i;
    slot_req_o.take       = 1'b0;
    slot_req_o.take_idx   = exp_idx;
    queue_req_o.push      = 1'b0;
    queue_req_o.push_tag  = buffer_tag_i;
    queue_req_o.pop       = 1'b0;
    load_del              = 1'b0;
    load_ack              = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          slot_req_o.store = ack_hit && !slot_valid_i[seq_idx];
          queue_req_o.push = (action_i == ACT_POST) && !queue_stat_i.full;
        end
      end
      ST_CHECK: begin
        if (deliver) begin
          slot_req_o.take = 1'b1;
          queue_req_o.pop = 1'b1;
        end
      end
      ST_EMIT: begin
        load_del = out_free;
      end
      ST_ACK: begin
        load_ack = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      next_exp_q <= '0;
      ack_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ack_q <= ack_hit;
      end
      if (slot_req_o.take) begin
        next_exp_q <= next_exp_q + 1'b1;
      end
    end
  end

  // Delivery in flight: its number, and whether nothing follows it.
  always_ff @(posedge clk_i) begin
    if (slot_req_o.take) begin
      del_seq_q  <= next_exp_q;
      del_last_q <= !ack_q && !more_after;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_del || load_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load_del) begin
      kind_q     <= KIND_DELIVER;
      seq_out_q  <= del_seq_q;
      pay_out_q  <= slot_tag_i;
      buf_out_q  <= queue_tag_i;
      ack_out_q  <= '0;
      last_out_q <= del_last_q;
    end else if (load_ack) begin
      kind_q     <= KIND_ACK;
      seq_out_q  <= '0;
      pay_out_q  <= '0;
      buf_out_q  <= '0;
      ack_out_q  <= next_exp_q;
      last_out_q <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign delivered_seq_o     = seq_out_q;
  assign delivered_payload_o = pay_out_q;
  assign target_buffer_o     = buf_out_q;
  assign ack_next_o          = ack_out_q;
  assign last_o              = last_out_q;

endmodule

`default_nettype wire

### src/receive_reorder_window.sv
// Top level of the receive reorder window: configuration register and the
// slot store, buffer queue and sequencer.
// Depends on rrw_pkg, rrw_slot_store, rrw_buf_queue and rrw_seq.
//
//   Channel  Direction  Handshake                  Carries
//   in       input      in_valid_i / in_ready_o    action, seq_num, payload_tag, buffer_tag
//   out      output     out_valid_o / out_ready_i  kind, delivered_seq, delivered_payload,
//                                                  target_buffer, ack_next, last
//   cfg      input      cfg_valid_i / cfg_ready_o  recv_window
//
// An item is taken in the idle state; each delivery is one slot and queue read in the check
// state, with the registered read data loaded into the output register in the emit state,
// issued by the sequencer one at a time, and an ack, when due, follows in the ack state.
// Reset clears the slot valid bits, the queue pointers and the next expected number;
// the memories start undefined and need no clearing pass.
// A stalled output holds the sequencer in its emit or ack state; the last result of an
// item may wait in the output register while the next item is taken.
`default_nettype none

module receive_reorder_window
  import rrw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write channel.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [RWIN_W-1:0] cfg_recv_window_i,
  // Input channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [SEQ_W-1:0]  seq_num_i,
  input  wire logic [TAG_W-1:0]  payload_tag_i,
  input  wire logic [TAG_W-1:0]  buffer_tag_i,
  // Output channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [SEQ_W-1:0]       delivered_seq_o,
  output logic [TAG_W-1:0]       delivered_payload_o,
  output logic [TAG_W-1:0]       target_buffer_o,
  output logic [SEQ_W-1:0]       ack_next_o,
  output logic                   last_o
);

  logic [RWIN_W-1:0] recv_window_q;
  slot_req_t         slot_req;
  logic [WINDOW-1:0] slot_valid;
  logic [TAG_W-1:0]  slot_tag;
  queue_req_t        queue_req;
  queue_stat_t       queue_stat;
  logic [TAG_W-1:0]  queue_tag;

  // Window size register; a transfer is taken in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_window_q <= RWIN_W'(32);
    end else if (cfg_valid_i && cfg_ready_o) begin
      recv_window_q <= cfg_recv_window_i;
    end
  end

  // Packet slots.
  rrw_slot_store u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (slot_req),
    .valid_o  (slot_valid),
    .rd_tag_o (slot_tag)
  );

  // Posted receive buffers.
  rrw_buf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (queue_req),
    .stat_o   (queue_stat),
    .rd_tag_o (queue_tag)
  );

  // Window check, delivery loop and output register.
  rrw_seq u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .recv_window_i       (recv_window_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .seq_num_i           (seq_num_i),
    .payload_tag_i       (payload_tag_i),
    .buffer_tag_i        (buffer_tag_i),
    .slot_req_o          (slot_req),
    .slot_valid_i        (slot_valid),
    .slot_tag_i          (slot_tag),
    .queue_req_o         (queue_req),
    .queue_stat_i        (queue_stat),
    .queue_tag_i         (queue_tag),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .delivered_seq_o     (delivered_seq_o),
    .delivered_payload_o (delivered_payload_o),
    .target_buffer_o     (target_buffer_o),
    .ack_next_o          (ack_next_o),
    .last_o              (last_o)
  );

  // One item at a time: no input transfer right after one.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken in the cycle after a transfer");

  // A slot is handed out only while it holds a packet.
  a_take_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_req.take |-> slot_valid[slot_req.take_idx])
    else $error("delivery from an empty slot");

  // Every delivery pops a buffer, and never from an empty queue.
  a_pop_pairs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_req.pop |-> (slot_req.take && !queue_stat.empty))
    else $error("buffer pop without a matching delivery");

  // No buffer is pushed into a full queue.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_req.push |-> !queue_stat.full)
    else $error("push into a full buffer queue");

endmodule

`default_nettype wire
